### sv/gte_pkg.sv
// gte_pkg: shared types, constants and helpers of the geodetic to ecef converter
// no dependencies
package gte_pkg;

  localparam int ANG_W    = 32;
  localparam int H_W      = 42;
  localparam int LEN_W    = 40;
  localparam int OUT_W    = 48;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 4;

  localparam int ANGLE_BITS         = 32;
  localparam int TRIG_FRAC_BITS_DEF = 32;

  localparam logic [63:0] ANGLE_MASK  = 64'((65'(1) << ANGLE_BITS) - 65'(1));
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q62_ONE     = 64'(1) << 62;
  localparam logic [61:0] RADIAL_MAX  = '1;

  localparam logic [LEN_W-1:0] EQ_RESET  = 40'd6378137000;
  localparam logic [LEN_W-1:0] POL_RESET = 40'd6356752314;

  localparam int TRIG_LAT = 56;
  localparam int RAD_LAT  = 128;
  localparam int SC_LAT   = 4;
  localparam int GTE_LAT  = TRIG_LAT + RAD_LAT + 2 + 2 * SC_LAT;

  typedef enum logic {
    REG_EQ  = 1'b0,
    REG_POL = 1'b1
  } reg_e;

  typedef struct packed {
    logic signed [H_W-1:0]   height;
    logic signed [ANG_W-1:0] latitude;
    logic signed [ANG_W-1:0] longitude;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coord_e;
    logic signed [OUT_W-1:0] coord_f;
    logic signed [OUT_W-1:0] coord_g;
  } res_t;

  // shift that brings the top set bit to bit 39
  function automatic logic [5:0] norm_shift(logic [LEN_W-1:0] v);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if (v[k]) begin
        n = 6'(LEN_W - 1 - k);
      end
    end
    return n;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat48(logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < -64'sh0000_8000_0000_0000) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/gte_mul.sv
// gte_mul: unsigned multiplier cut into 32 by 32 partial products, two register stages
// no dependencies
module gte_mul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int SW = (NA + NB) * 32;

  logic [NA*32-1:0] a_ext;
  logic [NB*32-1:0] b_ext;
  logic [63:0]      pp_q [NA*NB];
  logic [SW-1:0]    acc;

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_q[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= acc[AW+BW-1:0];
  end

endmodule

### sv/gte_dly.sv
// gte_dly: fixed delay line that keeps side data aligned with the pipeline
// no dependencies
module gte_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

### sv/gte_trig.sv
// gte_trig: pipelined sine and cosine of a binary angle, octant folding and taylor terms
// depends on gte_pkg, gte_mul, gte_dly
module gte_trig #(
  parameter int TRIG_FRAC_BITS = gte_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic [gte_pkg::ANG_W-1:0]       ang_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import gte_pkg::*;

  localparam int T  = TRIG_FRAC_BITS;
  localparam int TW = T + 2;
  localparam int NT = 10;
  localparam logic [63:0] RND = 64'(1) << (61 - T);

  logic [63:0]  a64, u;
  logic [61:0]  rem_d, rem_q;
  logic [2:0]   oct_q, oct_d;
  logic [124:0] px;
  logic [127:0] pxx;
  logic [63:0]  x, xd, x2;

  logic [63:0] ct [NT+1];
  logic [63:0] st [NT+1];
  logic [63:0] cs [NT+1];
  logic [63:0] ss [NT+1];
  logic [63:0] x2s [NT+1];

  always_comb begin
    a64   = 64'(ang_i) & ANGLE_MASK;
    u     = a64 << (64 - ANGLE_BITS);
    rem_d = u[61] ? (62'(1) << 61) - {1'b0, u[60:0]} : {1'b0, u[60:0]};
  end

  always_ff @(posedge clk_i) begin
    oct_q <= u[63:61];
    rem_q <= rem_d;
  end

  gte_mul #(.AW(62), .BW(63)) u_mx (
    .clk_i, .a_i(rem_q), .b_i(HALF_PI_Q62[62:0]), .p_o(px)
  );
  assign x = 64'(px[124:62]);

  gte_mul #(.AW(64), .BW(64)) u_mxx (.clk_i, .a_i(x), .b_i(x), .p_o(pxx));
  assign x2 = pxx[125:62];

  gte_dly #(.W(64), .N(2)) u_xd (.clk_i, .d_i(x), .q_o(xd));
  gte_dly #(.W(3), .N(54)) u_od (.clk_i, .d_i(oct_q), .q_o(oct_d));

  assign ct[0]  = Q62_ONE;
  assign st[0]  = xd;
  assign cs[0]  = Q62_ONE;
  assign ss[0]  = xd;
  assign x2s[0] = x2;

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam logic [63:0] DC = 64'((2*i+1) * (2*i+2));
    localparam logic [63:0] DS = 64'((2*i+2) * (2*i+3));
    localparam logic [71:0] MC = 72'((73'(1) << 72) / 73'(DC));
    localparam logic [71:0] MS = 72'((73'(1) << 72) / 73'(DS));

    logic [127:0] pcf, psf;
    logic [63:0]  pc, ps;
    logic [135:0] qcf, qsf;
    logic [127:0] pd;
    logic [191:0] ad;
    logic [63:0]  qc0, qs0, rc, rs, qc, qs;
    logic [63:0]  ct_q, st_q, cs_q, ss_q, x2_q;

    gte_mul #(.AW(64), .BW(64)) u_mc (.clk_i, .a_i(ct[i]), .b_i(x2s[i]), .p_o(pcf));
    gte_mul #(.AW(64), .BW(64)) u_ms (.clk_i, .a_i(st[i]), .b_i(x2s[i]), .p_o(psf));
    assign pc = pcf[125:62];
    assign ps = psf[125:62];

    gte_mul #(.AW(64), .BW(72)) u_dc (.clk_i, .a_i(pc), .b_i(MC), .p_o(qcf));
    gte_mul #(.AW(64), .BW(72)) u_ds (.clk_i, .a_i(ps), .b_i(MS), .p_o(qsf));
    gte_dly #(.W(128), .N(2)) u_pd (.clk_i, .d_i({pc, ps}), .q_o(pd));
    gte_dly #(.W(192), .N(4)) u_ad (.clk_i, .d_i({cs[i], ss[i], x2s[i]}), .q_o(ad));

    // reciprocal quotient is at most one low
    always_comb begin
      qc0 = qcf[135:72];
      qs0 = qsf[135:72];
      rc  = pd[127:64] - qc0 * DC;
      rs  = pd[63:0] - qs0 * DS;
      qc  = (rc >= DC) ? qc0 + 64'd1 : qc0;
      qs  = (rs >= DS) ? qs0 + 64'd1 : qs0;
    end

    always_ff @(posedge clk_i) begin
      ct_q <= qc;
      st_q <= qs;
      x2_q <= ad[63:0];
      if (i % 2 == 0) begin
        cs_q <= ad[191:128] - qc;
        ss_q <= ad[127:64] - qs;
      end else begin
        cs_q <= ad[191:128] + qc;
        ss_q <= ad[127:64] + qs;
      end
    end

    assign ct[i+1]  = ct_q;
    assign st[i+1]  = st_q;
    assign cs[i+1]  = cs_q;
    assign ss[i+1]  = ss_q;
    assign x2s[i+1] = x2_q;
  end

  logic [63:0]          sr, cr;
  logic [2:0]           o_p1, o_p2;
  logic signed [TW-1:0] sv, cv, s_sw, c_sw;

  always_comb begin
    sr   = (ss[NT] + RND) >> (62 - T);
    cr   = (cs[NT] + RND) >> (62 - T);
    sv   = TW'(sr[T:0]);
    cv   = TW'(cr[T:0]);
    o_p1 = oct_d + 3'd1;
    o_p2 = oct_d + 3'd2;
    s_sw = o_p1[1] ? cv : sv;
    c_sw = o_p1[1] ? sv : cv;
  end

  always_ff @(posedge clk_i) begin
    sin_o <= oct_d[2] ? -s_sw : s_sw;
    cos_o <= o_p2[2] ? -c_sw : c_sw;
  end

endmodule

### sv/gte_scale.sv
// gte_scale: signed length times signed trig value, rounded half away from zero
// depends on gte_mul, gte_dly
module gte_scale #(
  parameter int TRIG_FRAC_BITS = 32
) (
  input  logic                             clk_i,
  input  logic signed [63:0]               x_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] t_i,
  output logic signed [63:0]               y_o
);

  localparam int T = TRIG_FRAC_BITS;

  logic [63:0]    mx_q;
  logic [T:0]     mt_q;
  logic           neg_q, neg_d;
  logic [64+T:0]  p;
  logic [64+T:0]  pr;
  logic [T+1:0]   t_abs;

  assign t_abs = t_i[T+1] ? -t_i : t_i;

  always_ff @(posedge clk_i) begin
    mx_q  <= x_i[63] ? -x_i : x_i;
    mt_q  <= t_abs[T:0];
    neg_q <= x_i[63] ^ t_i[T+1];
  end

  gte_mul #(.AW(64), .BW(T+1)) u_m (.clk_i, .a_i(mx_q), .b_i(mt_q), .p_o(p));
  gte_dly #(.W(1), .N(2)) u_nd (.clk_i, .d_i(neg_q), .q_o(neg_d));

  assign pr = (p + ((65+T)'(1) << (T - 1))) >> T;

  always_ff @(posedge clk_i) begin
    y_o <= neg_d ? -$signed(pr[63:0]) : $signed(pr[63:0]);
  end

endmodule

### sv/gte_radial.sv
// gte_radial: prime vertical terms a^2/r and b^2/r, with a root and a divider pipeline
// depends on gte_pkg, gte_mul
module gte_radial #(
  parameter int TRIG_FRAC_BITS = gte_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic [gte_pkg::LEN_W-1:0]        eq_i,
  input  logic [gte_pkg::LEN_W-1:0]        pol_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cl_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sl_i,
  output logic [61:0]                      nc_o,
  output logic [61:0]                      ns_o
);
  import gte_pkg::*;

  localparam int T  = TRIG_FRAC_BITS;
  localparam int RS = T - 16;
  localparam int NQ = 62;
  localparam int NR = 57;

  // radius normalization, follows the registers
  logic [LEN_W-1:0] bsel, mx;
  logic [LEN_W-1:0] ka_q, kb_q;
  logic [5:0]       sh_q;
  logic             az_q;
  logic [79:0]      sqa, sqb;
  logic [95:0]      numa_q, numb_q;

  always_comb begin
    bsel = (pol_i != '0) ? pol_i : eq_i;
    mx   = (eq_i > bsel) ? eq_i : bsel;
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= norm_shift(mx);
    ka_q   <= eq_i << norm_shift(mx);
    kb_q   <= bsel << norm_shift(mx);
    az_q   <= (eq_i == '0);
    numa_q <= {sqa, 16'b0} >> sh_q;
    numb_q <= {sqb, 16'b0} >> sh_q;
  end

  gte_mul #(.AW(40), .BW(40)) u_sqa (.clk_i, .a_i(ka_q), .b_i(ka_q), .p_o(sqa));
  gte_mul #(.AW(40), .BW(40)) u_sqb (.clk_i, .a_i(kb_q), .b_i(kb_q), .p_o(sqb));

  // u = a |cos|, v = b |sin|
  logic [T+1:0]  cabs, sabs;
  logic [T:0]    mc_q, ms_q;
  logic [40+T:0] pu, pv, ru, rv;
  logic [56:0]   u_q, v_q;
  logic [113:0]  uu, vv;
  logic [113:0]  rad_q;

  assign cabs = cl_i[T+1] ? -cl_i : cl_i;
  assign sabs = sl_i[T+1] ? -sl_i : sl_i;

  always_ff @(posedge clk_i) begin
    mc_q <= cabs[T:0];
    ms_q <= sabs[T:0];
  end

  gte_mul #(.AW(40), .BW(T+1)) u_mu (.clk_i, .a_i(ka_q), .b_i(mc_q), .p_o(pu));
  gte_mul #(.AW(40), .BW(T+1)) u_mv (.clk_i, .a_i(kb_q), .b_i(ms_q), .p_o(pv));

  if (RS == 0) begin : g_nrnd
    assign ru = pu;
    assign rv = pv;
  end else begin : g_rnd
    assign ru = (pu + ((41+T)'(1) << (RS - 1))) >> RS;
    assign rv = (pv + ((41+T)'(1) << (RS - 1))) >> RS;
  end

  always_ff @(posedge clk_i) begin
    u_q <= ru[56:0];
    v_q <= rv[56:0];
  end

  gte_mul #(.AW(57), .BW(57)) u_uu (.clk_i, .a_i(u_q), .b_i(u_q), .p_o(uu));
  gte_mul #(.AW(57), .BW(57)) u_vv (.clk_i, .a_i(v_q), .b_i(v_q), .p_o(vv));

  always_ff @(posedge clk_i) begin
    rad_q <= uu + vv;
  end

  // integer square root, one result bit per stage
  logic [59:0]  srem  [NR+1];
  logic [56:0]  sroot [NR+1];
  logic [113:0] srad  [NR+1];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad_q;

  for (genvar j = 0; j < NR; j++) begin : g_sqrt
    logic [59:0]  rp, tr;
    logic [59:0]  r_q;
    logic [56:0]  t_q;
    logic [113:0] g_q;

    assign rp = {srem[j][57:0], srad[j][113:112]};
    assign tr = {1'b0, sroot[j], 2'b01};

    always_ff @(posedge clk_i) begin
      g_q <= srad[j] << 2;
      if (rp >= tr) begin
        r_q <= rp - tr;
        t_q <= {sroot[j][55:0], 1'b1};
      end else begin
        r_q <= rp;
        t_q <= {sroot[j][55:0], 1'b0};
      end
    end

    assign srem[j+1]  = r_q;
    assign sroot[j+1] = t_q;
    assign srad[j+1]  = g_q;
  end

  // rounded quotient (2 num + r) / 2r, one quotient bit per stage
  for (genvar k = 0; k < 2; k++) begin : g_lane
    logic [95:0] num;
    logic [97:0] nn;
    logic [57:0] dv;
    logic [57:0] drem [NQ+1];
    logic [61:0] dq   [NQ+1];
    logic [61:0] dn   [NQ+1];
    logic [57:0] dd   [NQ+1];
    logic        dsat [NQ+1];
    logic        dz   [NQ+1];
    logic [57:0] rem0_q, d0_q;
    logic [61:0] n0_q;
    logic        sat0_q, z0_q;
    logic [61:0] res_q;

    assign num = (k == 0) ? numa_q : numb_q;
    assign nn  = 98'({num, 1'b0}) + 98'(sroot[NR]);
    assign dv  = {sroot[NR], 1'b0};

    always_ff @(posedge clk_i) begin
      sat0_q <= 58'(nn[97:62]) >= dv;
      rem0_q <= 58'(nn[97:62]);
      n0_q   <= nn[61:0];
      d0_q   <= dv;
      z0_q   <= az_q | (sroot[NR] == '0);
    end

    assign drem[0] = rem0_q;
    assign dq[0]   = '0;
    assign dn[0]   = n0_q;
    assign dd[0]   = d0_q;
    assign dsat[0] = sat0_q;
    assign dz[0]   = z0_q;

    for (genvar m = 0; m < NQ; m++) begin : g_step
      logic [58:0] rp;
      logic        ge;
      logic [57:0] r_q, d_q;
      logic [61:0] q_q, n_q;
      logic        s_q, z_q;

      assign rp = {drem[m], dn[m][61]};
      assign ge = rp >= {1'b0, dd[m]};

      always_ff @(posedge clk_i) begin
        r_q <= ge ? 58'(rp - {1'b0, dd[m]}) : rp[57:0];
        q_q <= {dq[m][60:0], ge};
        n_q <= dn[m] << 1;
        d_q <= dd[m];
        s_q <= dsat[m];
        z_q <= dz[m];
      end

      assign drem[m+1] = r_q;
      assign dq[m+1]   = q_q;
      assign dn[m+1]   = n_q;
      assign dd[m+1]   = d_q;
      assign dsat[m+1] = s_q;
      assign dz[m+1]   = z_q;
    end

    always_ff @(posedge clk_i) begin
      if (dz[NQ]) begin
        res_q <= '0;
      end else if (dsat[NQ]) begin
        res_q <= RADIAL_MAX;
      end else begin
        res_q <= dq[NQ];
      end
    end
  end

  assign nc_o = g_lane[0].res_q;
  assign ns_o = g_lane[1].res_q;

endmodule

### sv/geodetic_to_ecef.sv
// geodetic_to_ecef: top level, register port, trig, radial and scaling pipelines
// depends on gte_pkg, gte_trig, gte_radial, gte_scale, gte_dly
//
//   channel   signals                              direction   handshake
//   request   start, req_i, busy                   in          start & !busy
//   result    done_o, res_o                        out         one-cycle strobe
//   config    psel penable pwrite paddr pwdata     in/out      apb, pready tied high
//
// one request per cycle; the result passes the two taylor series chains, the root
// and the quotient bit stages.
// busy stays low; reset clears only the valid chain and the radius registers.
// the result side takes every strobe, so nothing in the pipeline ever stalls.
module geodetic_to_ecef #(
  parameter int TRIG_FRAC_BITS = gte_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  gte_pkg::req_t               req_i,
  output logic                        busy,
  output logic                        done_o,
  output gte_pkg::res_t               res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gte_pkg::ADDR_W-1:0]  paddr,
  input  logic [gte_pkg::CFG_W-1:0]   pwdata,
  output logic [gte_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);
  import gte_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  logic [LEN_W-1:0] eq_q, pol_q;
  reg_e             sel;

  assign sel    = reg_e'(paddr[3]);
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q  <= EQ_RESET;
      pol_q <= POL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_EQ:  eq_q  <= pwdata[LEN_W-1:0];
        REG_POL: pol_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_EQ:  prdata = CFG_W'(eq_q);
      REG_POL: prdata = CFG_W'(pol_q);
      default: prdata = '0;
    endcase
  end

  logic [GTE_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[GTE_LAT-2:0], start & ~busy};
    end
  end

  assign done_o = vld_q[GTE_LAT-1];

  logic signed [TW-1:0]  sl, cl, so, co, sld, cld, sod, cod;
  logic signed [H_W-1:0] h_d;
  logic [61:0]           nc, ns;
  logic signed [63:0]    xe_q, xg_q, re, ev, fv, gv, gd;

  gte_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lat (
    .clk_i, .ang_i(req_i.latitude), .sin_o(sl), .cos_o(cl)
  );
  gte_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lon (
    .clk_i, .ang_i(req_i.longitude), .sin_o(so), .cos_o(co)
  );

  gte_dly #(.W(H_W), .N(TRIG_LAT + RAD_LAT)) u_hd (
    .clk_i, .d_i(req_i.height), .q_o(h_d)
  );

  gte_radial #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rad (
    .clk_i, .eq_i(eq_q), .pol_i(pol_q), .cl_i(cl), .sl_i(sl), .nc_o(nc), .ns_o(ns)
  );

  gte_dly #(.W(2*TW), .N(RAD_LAT + 1)) u_latd (
    .clk_i, .d_i({sl, cl}), .q_o({sld, cld})
  );
  gte_dly #(.W(2*TW), .N(RAD_LAT + 1 + SC_LAT)) u_lond (
    .clk_i, .d_i({so, co}), .q_o({sod, cod})
  );

  always_ff @(posedge clk_i) begin
    xe_q <= $signed(64'(nc)) + 64'(h_d);
    xg_q <= $signed(64'(ns)) + 64'(h_d);
  end

  gte_scale #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sre (
    .clk_i, .x_i(xe_q), .t_i(cld), .y_o(re)
  );
  gte_scale #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sg (
    .clk_i, .x_i(xg_q), .t_i(sld), .y_o(gv)
  );
  gte_dly #(.W(64), .N(SC_LAT)) u_gd (.clk_i, .d_i(gv), .q_o(gd));

  gte_scale #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_se (
    .clk_i, .x_i(re), .t_i(cod), .y_o(ev)
  );
  gte_scale #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sf (
    .clk_i, .x_i(re), .t_i(sod), .y_o(fv)
  );

  res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.coord_e <= sat48(ev);
    res_q.coord_f <= sat48(fv);
    res_q.coord_g <= sat48(gd);
  end

  assign res_o = res_q;

endmodule

### sv/gte_chk.sv
// gte_chk: port-level checks of the converter, bound to the top level
// depends on gte_pkg, geodetic_to_ecef
module gte_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [gte_pkg::ADDR_W-1:0] paddr,
  input logic [gte_pkg::CFG_W-1:0]  pwdata,
  input logic [gte_pkg::CFG_W-1:0]  prdata
);
  import gte_pkg::*;

  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !done_o)
    else $error("result strobe right after reset");

  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##GTE_LAT done_o)
    else $error("request without result");

  a_res_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, GTE_LAT))
    else $error("result without request");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=>
      (paddr[3] != $past(paddr[3])) || (prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))
    else $error("register readback mismatch");

endmodule

bind geodetic_to_ecef gte_chk u_gte_chk (.*);
